// ----- design/cffb_pkg.sv -----
// ----------------------------------------------------------------------------
// cffb_pkg
// Shared types and constants for the command frame builder: request and
// frame payloads, the converter-to-serialiser item and register indexes.
// ----------------------------------------------------------------------------
package cffb_pkg;

    // Frame geometry
    localparam int unsigned FRAME_BYTES = 5;
    localparam int unsigned BCD_BYTES   = FRAME_BYTES - 1;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SET_OPCODE  = 2'd0,
        REG_READ_OPCODE = 2'd1
    } t_reg_index;

    localparam logic [CFG_DATA_W-1:0] SET_OPCODE_RESET  = 8'd1;
    localparam logic [CFG_DATA_W-1:0] READ_OPCODE_RESET = 8'd3;

    // Command modes
    localparam logic MODE_SET_FREQ = 1'b0;
    localparam logic MODE_READ     = 1'b1;

    // Input request: one command
    typedef struct packed {
        logic        mode;
        logic [31:0] frequency_hz;
    } t_cmd;

    // Output request: one frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_frame;

    // Converted command handed to the serialiser; byte 0 in the top bits
    typedef struct packed {
        logic                    mode;
        logic [8*BCD_BYTES-1:0]  bcd;
    } t_bcd_item;

endpackage : cffb_pkg

// ----- design/cat_frequency_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// cat_frequency_frame_builder_core
// Builds five-byte command frames: a set-frequency frame carries digits 1..8
// of the frequency as packed BCD followed by the set opcode; a read request
// carries four zero bytes followed by the read opcode.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Payload
//  cmd      in   i_cmd_valid / o_cmd_ready  i_cmd  (t_cmd: mode, frequency_hz)
//  frm      out  o_frm_valid / i_frm_ready  o_frm  (t_frame: frame_byte, frame_last)
//  cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Each command yields five frame bytes, one per cycle while the output takes
//  them, all through the single byte-wide output. A request reaches the
//  first frame byte through the eight-stage converter pipeline and the
//  serialiser.
//  Reset (synchronous, active low) empties the pipeline and loads the opcode
//  registers with 1 and 3. An output stall holds the current byte and backs
//  up the converter stage by stage; new commands are taken while it has room.
// ----------------------------------------------------------------------------
module cat_frequency_frame_builder_core
    import cffb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  t_cmd                   i_cmd,
    output logic                   o_frm_valid,
    input  logic                   i_frm_ready,
    output t_frame                 o_frm,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_BYTES - 1);

    // Converter to serialiser
    logic      w_cv_valid;
    logic      w_cv_ready;
    t_bcd_item w_cv_item;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_set_opcode;
    logic [CFG_DATA_W-1:0] r_read_opcode;

    // Serialiser state
    logic                   r_valid;
    logic                   n_valid;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_mode;
    logic [8*BCD_BYTES-1:0] r_bytes;
    logic                   w_frm_take;
    logic                   w_is_last;

    cffb_bcd_pipe u_bcd_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_valid),
        .o_in_ready  (o_cmd_ready),
        .i_in        (i_cmd),
        .o_out_valid (w_cv_valid),
        .i_out_ready (w_cv_ready),
        .o_out       (w_cv_item)
    );

    // Register writes; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_opcode  <= SET_OPCODE_RESET;
            r_read_opcode <= READ_OPCODE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SET_OPCODE:  r_set_opcode  <= i_cfg_data;
                REG_READ_OPCODE: r_read_opcode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Serialiser control: take a new frame when idle or once the last byte leaves
    assign w_is_last  = (r_cnt == LAST_BYTE);
    assign w_frm_take = r_valid && i_frm_ready;
    assign w_cv_ready = !r_valid || (i_frm_ready && w_is_last);

    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        if (w_cv_ready) begin
            n_valid = w_cv_valid;
            n_cnt   = '0;
        end else if (w_frm_take) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    // Load a frame, then shift one byte out per accepted request
    always_ff @(posedge i_clk) begin
        if (w_cv_ready && w_cv_valid) begin
            r_mode  <= w_cv_item.mode;
            r_bytes <= w_cv_item.bcd;
        end else if (w_frm_take) begin
            r_bytes <= {r_bytes[8*BCD_BYTES-9:0], 8'h00};
        end
    end

    // Drive the frame byte: BCD bytes, then the opcode
    always_comb begin
        if (!w_is_last) begin
            o_frm.frame_byte = r_bytes[8*BCD_BYTES-1 -: 8];
        end else if (r_mode == MODE_READ) begin
            o_frm.frame_byte = r_read_opcode;
        end else begin
            o_frm.frame_byte = r_set_opcode;
        end
        o_frm.frame_last = w_is_last;
    end

    assign o_frm_valid = r_valid;

    // Counter returns to the first byte after a frame ends
    a_cnt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frm_take && w_is_last |=> r_cnt == '0)
        else $error("byte counter did not wrap after last byte");

    // Read requests carry zero bytes before the opcode
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_mode == MODE_READ && !w_is_last |-> o_frm.frame_byte == 8'h00)
        else $error("non-zero byte in read request");

    // Every BCD byte holds two decimal digits
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !w_is_last |->
            o_frm.frame_byte[7:4] <= 4'd9 && o_frm.frame_byte[3:0] <= 4'd9)
        else $error("frame byte is not packed BCD");

    // A stalled byte keeps its place in the frame
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_frm_ready |=> r_valid && $stable(r_cnt))
        else $error("frame position moved while stalled");

endmodule : cat_frequency_frame_builder_core

// ----- design/cffb_bcd_pipe.sv -----
// ----------------------------------------------------------------------------
// cffb_bcd_pipe
// Pipelined binary to packed-BCD converter. Strips the gigahertz and 1 Hz
// digits and returns digits 1..8 as four packed-BCD bytes, using constant
// reciprocal multiplications. Read requests give zero bytes.
// ----------------------------------------------------------------------------
module cffb_bcd_pipe
    import cffb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_cmd      i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_bcd_item o_out
);

    localparam int unsigned NSTAGE = 8;

    // Reciprocals: /10 exact for 32-bit values, /10000 exact below 4.9e8,
    // /100 exact below 43690
    localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [26:0] RECIP_1E4  = 27'd109951163;
    localparam logic [26:0] RECIP_100  = 27'd10486;

    // Split a value below one hundred into two BCD digits
    function automatic logic [7:0] pair_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(7'(tens) * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // Stage handshake
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE:0]   w_rdy;
    logic [NSTAGE-1:0] w_ld;

    // Stage payloads
    logic        r_mode [NSTAGE];
    logic [31:0] r_freq;
    logic [29:0] r_rem9;
    logic [26:0] r_q3;
    logic [26:0] r_q4;
    logic [13:0] r_hi4;
    logic [13:0] r_hi5;
    logic [13:0] r_lo5;
    logic [13:0] r_hi6;
    logic [13:0] r_lo6;
    logic [6:0]  r_hh6;
    logic [6:0]  r_lh6;
    logic [6:0]  r_hh7;
    logic [6:0]  r_hl7;
    logic [6:0]  r_lh7;
    logic [6:0]  r_ll7;
    logic [8*BCD_BYTES-1:0] r_bcd8;

    // Datapath nets
    logic [31:0] w_sub9;
    logic [61:0] w_prod3;
    logic [53:0] w_prod4;
    logic [26:0] w_prod5;
    logic [26:0] w_prod6_hi;
    logic [26:0] w_prod6_lo;
    logic [13:0] w_prod7_hi;
    logic [13:0] w_prod7_lo;
    logic [8*BCD_BYTES-1:0] w_bcd;

    // Ready ripples back through stages that are empty or draining
    always_comb begin
        w_rdy[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Load enables and next valid bits
    always_comb begin
        w_ld[0]  = w_rdy[0] && i_in_valid;
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            w_ld[k]  = w_rdy[k] && r_vld[k-1];
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Carry the mode down the pipe
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_mode[0] <= i_in.mode;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_ld[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
    end

    // Drop the gigahertz digit: subtract whole multiples of 1e9
    always_comb begin
        if (r_freq >= 32'd4000000000) begin
            w_sub9 = 32'd4000000000;
        end else if (r_freq >= 32'd3000000000) begin
            w_sub9 = 32'd3000000000;
        end else if (r_freq >= 32'd2000000000) begin
            w_sub9 = 32'd2000000000;
        end else if (r_freq >= 32'd1000000000) begin
            w_sub9 = 32'd1000000000;
        end else begin
            w_sub9 = 32'd0;
        end
    end

    // Drop the 1 Hz digit, split into upper and lower four digits, then each half into digit pairs
    assign w_prod3    = 62'(r_rem9) * 62'(RECIP_10);
    assign w_prod4    = 54'(r_q3) * 54'(RECIP_1E4);
    assign w_prod5    = 27'(r_hi4) * 27'd10000;
    assign w_prod6_hi = 27'(r_hi5) * RECIP_100;
    assign w_prod6_lo = 27'(r_lo5) * RECIP_100;
    assign w_prod7_hi = 14'(r_hh6) * 14'd100;
    assign w_prod7_lo = 14'(r_lh6) * 14'd100;

    // Pack the digit pairs; read requests send zeros
    always_comb begin
        if (r_mode[6] == MODE_READ) begin
            w_bcd = '0;
        end else begin
            w_bcd = {pair_to_bcd(r_hh7), pair_to_bcd(r_hl7),
                     pair_to_bcd(r_lh7), pair_to_bcd(r_ll7)};
        end
    end

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_freq <= i_in.frequency_hz;
        end
        if (w_ld[1]) begin
            r_rem9 <= 30'(r_freq - w_sub9);
        end
        if (w_ld[2]) begin
            r_q3 <= w_prod3[61:35];
        end
        if (w_ld[3]) begin
            r_q4  <= r_q3;
            r_hi4 <= w_prod4[53:40];
        end
        if (w_ld[4]) begin
            r_hi5 <= r_hi4;
            r_lo5 <= 14'(r_q4 - w_prod5);
        end
        if (w_ld[5]) begin
            r_hi6 <= r_hi5;
            r_lo6 <= r_lo5;
            r_hh6 <= w_prod6_hi[26:20];
            r_lh6 <= w_prod6_lo[26:20];
        end
        if (w_ld[6]) begin
            r_hh7 <= r_hh6;
            r_lh7 <= r_lh6;
            r_hl7 <= 7'(r_hi6 - w_prod7_hi);
            r_ll7 <= 7'(r_lo6 - w_prod7_lo);
        end
        if (w_ld[7]) begin
            r_bcd8 <= w_bcd;
        end
    end

    assign o_in_ready      = w_rdy[0];
    assign o_out_valid     = r_vld[NSTAGE-1];
    assign o_out.mode      = r_mode[NSTAGE-1];
    assign o_out.bcd       = r_bcd8;

    // Gigahertz digit removed: remainder below one billion
    a_rem9_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r_rem9 < 30'd1000000000)
        else $error("remainder after gigahertz strip out of range");

    // Both four-digit halves below ten thousand
    a_lo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> r_lo5 < 14'd10000 && r_hi5 < 14'd10000)
        else $error("four-digit split out of range");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTAGE-1] && !i_out_ready |=> r_vld[NSTAGE-1] && $stable(r_bcd8))
        else $error("converter result lost while stalled");

endmodule : cffb_bcd_pipe
